// ===== hw/rtl/clg_pkg.sv =====
package clg_pkg;

  localparam int unsigned SEED_W = 31;
  localparam int unsigned MULT_W = 16;
  localparam int unsigned PROD_W = SEED_W + MULT_W;
  localparam int unsigned FOLD_W = 8;

  localparam logic [MULT_W-1:0] MULT_ONE = 16'd40014;
  localparam logic [MULT_W-1:0] MULT_TWO = 16'd40692;
  localparam logic [SEED_W-1:0] MOD_ONE  = 31'd2147483563;
  localparam logic [SEED_W-1:0] MOD_TWO  = 31'd2147483399;
  // 2^31 - modulus: the weight of the high product bits after folding
  localparam logic [FOLD_W-1:0] FOLD_ONE = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD_TWO = 8'd249;
  localparam logic [SEED_W-1:0] WRAP_ADD = 31'd2147483562;
  localparam logic [SEED_W-1:0] MAX_ONE  = 31'd2147483562;
  localparam logic [SEED_W-1:0] MAX_TWO  = 31'd2147483398;

  localparam logic CMD_GEN  = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic LANE_ONE = 1'b0;
  localparam logic LANE_TWO = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_FIN
  } clg_state_e;

  typedef struct packed {
    logic mul_en;
    logic lane;
  } clg_ctrl_t;

endpackage

// ===== hw/rtl/clg_mulmod.sv =====
// Shared multiply / modular reduce unit. Product registered, reduction
// taken from the registered product in the following cycle.
module clg_mulmod (
  input  logic                           clk_i,
  input  clg_pkg::clg_ctrl_t             ctrl_i,
  input  logic [clg_pkg::SEED_W-1:0]     operand_i,
  output logic [clg_pkg::SEED_W-1:0]     result_o
);

  logic [clg_pkg::PROD_W-1:0] prod_d, prod_q;
  logic                       lane_q;
  logic [clg_pkg::MULT_W-1:0] mult;
  logic [clg_pkg::FOLD_W-1:0] fold_c;
  logic [clg_pkg::SEED_W-1:0] modulus;
  logic [clg_pkg::MULT_W-1:0] prod_hi;
  logic [clg_pkg::SEED_W-1:0] prod_lo;
  logic [23:0]                hi_fold;
  logic [31:0]                fold_sum;

  assign mult   = (ctrl_i.lane == clg_pkg::LANE_TWO) ? clg_pkg::MULT_TWO : clg_pkg::MULT_ONE;
  assign prod_d = clg_pkg::PROD_W'(operand_i) * clg_pkg::PROD_W'(mult);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
      lane_q <= ctrl_i.lane;
    end
  end

  // 2^31 == fold (mod m): p = hi*2^31 + lo == hi*fold + lo, which is < 2m
  assign fold_c  = (lane_q == clg_pkg::LANE_TWO) ? clg_pkg::FOLD_TWO : clg_pkg::FOLD_ONE;
  assign modulus = (lane_q == clg_pkg::LANE_TWO) ? clg_pkg::MOD_TWO : clg_pkg::MOD_ONE;
  assign prod_hi = prod_q[clg_pkg::PROD_W-1:clg_pkg::SEED_W];
  assign prod_lo = prod_q[clg_pkg::SEED_W-1:0];
  assign hi_fold = 24'(prod_hi) * 24'(fold_c);
  assign fold_sum = 32'(prod_lo) + 32'(hi_fold);

  always_comb begin
    if (fold_sum >= 32'(modulus)) begin
      result_o = clg_pkg::SEED_W'(fold_sum - 32'(modulus));
    end else begin
      result_o = clg_pkg::SEED_W'(fold_sum);
    end
  end

endmodule

// ===== hw/rtl/combined_lcg_generator.sv =====
// Sequence: a generate beat steps through ST_MUL and ST_RED for seed one, then for
//   seed two, then ST_FIN; a load beat goes straight to ST_FIN (output register free).
// Occupancy: a new beat is accepted only in ST_IDLE, after the last one has left ST_FIN;
//   set by the single shared 31x16 multiplier and fold reducer used once per seed.
// Reset: rst_ni async active low; both seeds return to 1, output empty.
module combined_lcg_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // new_seed_one[30:0], new_seed_two[61:31], zero pad
  input  logic        s_axis_tuser,   // cmd: 0 generate, 1 load
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // rand_value[30:0], old_seed_one[61:31],
                                      // old_seed_two[92:62], zero pad
  output logic        m_axis_tuser    // seed_error
);

  localparam int unsigned W = clg_pkg::SEED_W;

  clg_pkg::clg_state_e state_d, state_q;
  clg_pkg::clg_ctrl_t  ctrl;

  logic [W-1:0] seed_one_d, seed_one_q;
  logic [W-1:0] seed_two_d, seed_two_q;
  logic         lane_d, lane_q;
  logic         cmd_d, cmd_q;
  logic         err_d, err_q;
  logic [W-1:0] old_one_d, old_one_q;
  logic [W-1:0] old_two_d, old_two_q;

  logic         out_valid_d, out_valid_q;
  logic [W-1:0] out_value_d, out_value_q;
  logic [W-1:0] out_old_one_d, out_old_one_q;
  logic [W-1:0] out_old_two_d, out_old_two_q;
  logic         out_err_d, out_err_q;

  logic [W-1:0] new_one, new_two;
  logic [W-1:0] unit_result;
  logic [W-1:0] diff_value;
  logic         in_fire;
  logic         out_free;
  logic         load_ok;

  assign new_one = s_axis_tdata[W-1:0];
  assign new_two = s_axis_tdata[2*W-1:W];

  assign s_axis_tready = (state_q == clg_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // result register frees up in the same cycle it is drained
  assign out_free      = !out_valid_q || m_axis_tready;

  assign load_ok = (new_one != '0) && (new_one <= clg_pkg::MAX_ONE) &&
                   (new_two != '0) && (new_two <= clg_pkg::MAX_TWO);

  // combined output: s1 - s2, wrapped into 1..WRAP_ADD
  always_comb begin
    if (seed_one_q > seed_two_q) begin
      diff_value = seed_one_q - seed_two_q;
    end else begin
      diff_value = W'(32'(seed_one_q) + 32'(clg_pkg::WRAP_ADD) - 32'(seed_two_q));
    end
  end

  clg_mulmod u_mulmod (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .operand_i ((lane_q == clg_pkg::LANE_TWO) ? seed_two_q : seed_one_q),
    .result_o  (unit_result)
  );

  always_comb begin
    state_d       = state_q;
    seed_one_d    = seed_one_q;
    seed_two_d    = seed_two_q;
    lane_d        = lane_q;
    cmd_d         = cmd_q;
    err_d         = err_q;
    old_one_d     = old_one_q;
    old_two_d     = old_two_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_value_d   = out_value_q;
    out_old_one_d = out_old_one_q;
    out_old_two_d = out_old_two_q;
    out_err_d     = out_err_q;
    ctrl.mul_en   = 1'b0;
    ctrl.lane     = lane_q;

    unique case (state_q)
      clg_pkg::ST_IDLE: begin
        if (in_fire) begin
          old_one_d = seed_one_q;
          old_two_d = seed_two_q;
          cmd_d     = s_axis_tuser;
          err_d     = 1'b0;
          if (s_axis_tuser == clg_pkg::CMD_LOAD) begin
            if (load_ok) begin
              seed_one_d = new_one;
              seed_two_d = new_two;
            end else begin
              err_d = 1'b1;
            end
            state_d = clg_pkg::ST_FIN;
          end else begin
            lane_d  = clg_pkg::LANE_ONE;
            state_d = clg_pkg::ST_MUL;
          end
        end
      end
      clg_pkg::ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_d     = clg_pkg::ST_RED;
      end
      clg_pkg::ST_RED: begin
        if (lane_q == clg_pkg::LANE_ONE) begin
          seed_one_d = unit_result;
          lane_d     = clg_pkg::LANE_TWO;
          state_d    = clg_pkg::ST_MUL;
        end else begin
          seed_two_d = unit_result;
          state_d    = clg_pkg::ST_FIN;
        end
      end
      clg_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_value_d   = (cmd_q == clg_pkg::CMD_LOAD) ? '0 : diff_value;
          out_old_one_d = old_one_q;
          out_old_two_d = old_two_q;
          out_err_d     = err_q;
          state_d       = clg_pkg::ST_IDLE;
        end
      end
      default: state_d = clg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clg_pkg::ST_IDLE;
      seed_one_q  <= W'(1);
      seed_two_q  <= W'(1);
      lane_q      <= clg_pkg::LANE_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_one_q  <= seed_one_d;
      seed_two_q  <= seed_two_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    err_q         <= err_d;
    old_one_q     <= old_one_d;
    old_two_q     <= old_two_d;
    out_value_q   <= out_value_d;
    out_old_one_q <= out_old_one_d;
    out_old_two_q <= out_old_two_d;
    out_err_q     <= out_err_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_old_two_q, out_old_one_q, out_value_q};
  assign m_axis_tuser  = out_err_q;

endmodule

// ===== hw/rtl/clg_checker.sv =====
module clg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a beat while busy");

  // rejected load reports a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[30:0] == '0)
    else $error("error beat with nonzero value");

  // reported seeds and value are always in range
  a_seeds_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[61:31] != '0 && m_axis_tdata[92:62] != '0
      && m_axis_tdata[61:31] <= clg_pkg::MAX_ONE
      && m_axis_tdata[92:62] <= clg_pkg::MAX_TWO
      && m_axis_tdata[30:0] <= clg_pkg::WRAP_ADD)
    else $error("seed or value out of range");

endmodule

bind combined_lcg_generator clg_checker u_clg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
